@@ hdl/srt_pkg.sv @@
// srt_pkg: types, codes and constants shared by the sorted record table
`default_nettype none

package srt_pkg;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_RAISE  = 2'd2;
	localparam logic [1:0] OP_QUERY  = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_TOO_FEW   = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	localparam int KEY_W   = 32;
	localparam int PRICE_W = 24;
	localparam int STOCK_W = 16;
	localparam int RANK_W  = 16;
	localparam int PROD_W  = 2 * PRICE_W;

	localparam logic [PRICE_W-1:0] PRICE_MAX = 24'hFFFFFF;

	// floor(p / 10) == (p * RECIP10) >> RECIP_SH for every 24-bit p
	localparam logic [PRICE_W-1:0] RECIP10  = 24'hCCCCCD;
	localparam int                 RECIP_SH = 27;
	localparam int                 QUOT_W   = PROD_W - RECIP_SH;

	typedef struct packed {
		logic [1:0]                operation;
		logic [KEY_W-1:0]          item_code;
		logic [PRICE_W-1:0]        item_price;
		logic signed [STOCK_W-1:0] item_stock;
		logic [RANK_W-1:0]         rank;
	} srt_cmd_t;

	typedef struct packed {
		logic [2:0]                status;
		logic [KEY_W-1:0]          found_code;
		logic [PRICE_W-1:0]        new_price;
		logic signed [STOCK_W-1:0] found_stock;
	} srt_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       srch_rd;
		logic       srch_step;
		logic       shift_init;
		logic       shift_rd;
		logic       shift_wr;
		logic       put_new;
		logic       look_rd;
		logic       match_rd;
		logic       mul;
		logic       price_wr;
		logic       res_status;
		logic [2:0] status;
		logic       res_code;
		logic       res_stock;
		logic       emit;
	} srt_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       empty;
		logic       too_few;
		logic       srch_done;
		logic       shift_done;
		logic       match;
		logic       out_free;
	} srt_stat_t;

endpackage

`default_nettype wire

@@ hdl/srt_chan_if.sv @@
// srt_chan_if: valid/ready channel carrying one word of a given type
`default_nettype none

interface srt_chan_if #(
	parameter type data_t = logic
) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/srt_ctrl.sv @@
// srt_ctrl: sequencer for insert, lookup, raise and query commands
`default_nettype none

module srt_ctrl
	import srt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire srt_stat_t st,
	output srt_ctl_t       cm
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DECODE    = 4'd1;
	localparam logic [3:0] S_SRCH_RD   = 4'd2;
	localparam logic [3:0] S_SRCH_CMP  = 4'd3;
	localparam logic [3:0] S_SHIFT_RD  = 4'd4;
	localparam logic [3:0] S_SHIFT_WR  = 4'd5;
	localparam logic [3:0] S_LOOK_RD   = 4'd6;
	localparam logic [3:0] S_LOOK_GET  = 4'd7;
	localparam logic [3:0] S_MATCH_RD  = 4'd8;
	localparam logic [3:0] S_MATCH_CHK = 4'd9;
	localparam logic [3:0] S_PRICE_WR  = 4'd10;
	localparam logic [3:0] S_DONE      = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cm      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cm.load = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (st.op)
					OP_INSERT: begin
						if (st.full) begin
							cm.res_status = 1'b1;
							cm.status     = ST_FULL;
							state_d       = S_DONE;
						end else begin
							state_d = S_SRCH_RD;
						end
					end
					OP_LOOKUP: begin
						if (st.empty) begin
							cm.res_status = 1'b1;
							cm.status     = ST_EMPTY;
							state_d       = S_DONE;
						end else if (st.too_few) begin
							cm.res_status = 1'b1;
							cm.status     = ST_TOO_FEW;
							state_d       = S_DONE;
						end else begin
							state_d = S_LOOK_RD;
						end
					end
					default: state_d = S_SRCH_RD;
				endcase
			end
			S_SRCH_RD: begin
				if (st.srch_done) begin
					if (st.op == OP_INSERT) begin
						cm.shift_init = 1'b1;
						state_d       = S_SHIFT_RD;
					end else begin
						state_d = S_MATCH_RD;
					end
				end else begin
					cm.srch_rd = 1'b1;
					state_d    = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				cm.srch_step = 1'b1;
				state_d      = S_SRCH_RD;
			end
			S_SHIFT_RD: begin
				// open slot reached: drop the new record in
				if (st.shift_done) begin
					cm.put_new = 1'b1;
					state_d    = S_DONE;
				end else begin
					cm.shift_rd = 1'b1;
					state_d     = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cm.shift_wr = 1'b1;
				state_d     = S_SHIFT_RD;
			end
			S_LOOK_RD: begin
				cm.look_rd = 1'b1;
				state_d    = S_LOOK_GET;
			end
			S_LOOK_GET: begin
				cm.res_code = 1'b1;
				state_d     = S_DONE;
			end
			S_MATCH_RD: begin
				cm.match_rd = 1'b1;
				state_d     = S_MATCH_CHK;
			end
			S_MATCH_CHK: begin
				if (!st.match) begin
					cm.res_status = 1'b1;
					cm.status     = ST_NOT_FOUND;
					state_d       = S_DONE;
				end else if (st.op == OP_QUERY) begin
					cm.res_stock = 1'b1;
					state_d      = S_DONE;
				end else begin
					cm.mul  = 1'b1;
					state_d = S_PRICE_WR;
				end
			end
			S_PRICE_WR: begin
				cm.price_wr = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cm.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/srt_dp.sv @@
// srt_dp: record memories, search bounds, price arithmetic and output register
`default_nettype none

module srt_dp
	import srt_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire srt_cmd_t in_data,
	input  wire srt_ctl_t cm,
	output srt_stat_t     st,
	output logic          out_valid,
	input  wire logic     out_ready,
	output srt_rsp_t      out_data,
	output logic [CW-1:0] entry_count
);

	logic [KEY_W-1:0]   key_mem   [DEPTH];
	logic [PRICE_W-1:0] price_mem [DEPTH];
	logic [STOCK_W-1:0] stock_mem [DEPTH];

	logic [1:0]          op_q;
	logic [KEY_W-1:0]    code_q;
	logic [PRICE_W-1:0]  price_q;
	logic [STOCK_W-1:0]  stock_q;
	logic [RANK_W-1:0]   rank_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       lo_q;
	logic [CW-1:0]       hi_q;
	logic [CW-1:0]       j_q;
	logic [KEY_W-1:0]    key_rd_q;
	logic [PRICE_W-1:0]  price_rd_q;
	logic [STOCK_W-1:0]  stock_rd_q;
	logic [PROD_W-1:0]   prod_s1;
	srt_rsp_t            res_q;
	logic                out_valid_q;
	srt_rsp_t            out_q;

	logic [CW:0]         lh_sum;
	logic [CW-1:0]       mid;
	logic [CW-1:0]       mid_p1;
	logic [CW-1:0]       j_m1;
	logic [RANK_W-1:0]   rank_eff;
	logic [RANK_W-1:0]   rank_m1;
	logic [AW-1:0]       rd_addr;
	logic                rd_en;
	logic [AW-1:0]       wr_addr;
	logic                rec_we;
	logic                price_we;
	logic [KEY_W-1:0]    key_wd;
	logic [PRICE_W-1:0]  price_wd;
	logic [STOCK_W-1:0]  stock_wd;
	logic [QUOT_W-1:0]   quot;
	logic [PRICE_W:0]    raised;
	logic [PRICE_W-1:0]  raised_sat;

	// lower-bound binary search over [lo, hi)
	assign lh_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = lh_sum[CW:1];
	assign mid_p1   = mid + CW'(1);
	assign j_m1     = j_q - CW'(1);
	assign rank_eff = (rank_q == '0) ? RANK_W'(1) : rank_q;
	assign rank_m1  = rank_eff - RANK_W'(1);

	assign quot       = prod_s1[PROD_W-1:RECIP_SH];
	assign raised     = {1'b0, price_rd_q} + (PRICE_W+1)'(quot);
	assign raised_sat = raised[PRICE_W] ? PRICE_MAX : raised[PRICE_W-1:0];

	always_comb begin
		rd_addr = mid[AW-1:0];
		if (cm.look_rd) begin
			rd_addr = rank_m1[AW-1:0];
		end else if (cm.match_rd) begin
			rd_addr = lo_q[AW-1:0];
		end else if (cm.shift_rd) begin
			rd_addr = j_m1[AW-1:0];
		end
	end

	assign rd_en    = cm.srch_rd | cm.look_rd | cm.match_rd | cm.shift_rd;
	assign rec_we   = cm.shift_wr | cm.put_new;
	assign price_we = rec_we | cm.price_wr;
	assign wr_addr  = cm.shift_wr ? j_q[AW-1:0] : lo_q[AW-1:0];

	always_comb begin
		key_wd   = code_q;
		price_wd = price_q;
		stock_wd = stock_q;
		if (cm.shift_wr) begin
			key_wd   = key_rd_q;
			price_wd = price_rd_q;
			stock_wd = stock_rd_q;
		end else if (cm.price_wr) begin
			price_wd = raised_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			key_mem[wr_addr]   <= key_wd;
			stock_mem[wr_addr] <= stock_wd;
		end
		if (price_we) begin
			price_mem[wr_addr] <= price_wd;
		end
		if (rd_en) begin
			key_rd_q   <= key_mem[rd_addr];
			price_rd_q <= price_mem[rd_addr];
			stock_rd_q <= stock_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cm.load) begin
			op_q    <= in_data.operation;
			code_q  <= in_data.item_code;
			price_q <= in_data.item_price;
			stock_q <= in_data.item_stock;
			rank_q  <= in_data.rank;
			lo_q    <= '0;
			hi_q    <= count_q;
			res_q   <= '0;
		end
		if (cm.srch_step) begin
			if (key_rd_q < code_q) begin
				lo_q <= mid_p1;
			end else begin
				hi_q <= mid;
			end
		end
		if (cm.shift_init) begin
			j_q <= count_q;
		end else if (cm.shift_wr) begin
			j_q <= j_m1;
		end
		if (cm.mul) begin
			prod_s1 <= price_rd_q * RECIP10;
		end
		if (cm.res_status) begin
			res_q.status <= cm.status;
		end
		if (cm.res_code) begin
			res_q.found_code <= key_rd_q;
		end
		if (cm.res_stock) begin
			res_q.found_stock <= stock_rd_q;
		end
		if (cm.price_wr) begin
			res_q.new_price <= raised_sat;
		end
		if (cm.emit) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cm.put_new) begin
				count_q <= count_q + CW'(1);
			end
			if (cm.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st.op         = op_q;
	assign st.full       = (count_q == CW'(DEPTH));
	assign st.empty      = (count_q == '0);
	assign st.too_few    = (rank_eff > RANK_W'(count_q));
	assign st.srch_done  = (lo_q == hi_q);
	assign st.shift_done = (j_q == lo_q);
	assign st.match      = (lo_q < count_q) && (key_rd_q == code_q);
	assign st.out_free   = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_data    = out_q;
	assign entry_count = count_q;

endmodule

`default_nettype wire

@@ hdl/sorted_record_table.sv @@
// sorted_record_table: key-ordered record table with insert, rank lookup, raise and query
// at most ceil(log2(n+1)) search steps over n entries; insert moves later entries up one slot
// full table on insert, empty table or rank beyond count on lookup: status code set at decode
// one word at a time: the next is taken in the same cycle the result appears, even while it waits
// reset clears the entry count; memory contents stay undefined and are never cleared
`default_nettype none

module sorted_record_table
	import srt_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	srt_chan_if.sink   cmd,
	srt_chan_if.source rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	srt_ctl_t      cm;
	srt_stat_t     st;
	logic          in_ready;
	logic [CW-1:0] entry_count;

	assign cmd.ready = in_ready;

	srt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (in_ready),
		.st       (st),
		.cm       (cm)
	);

	srt_dp #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (cmd.data),
		.cm          (cm),
		.st          (st),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_data    (rsp.data),
		.entry_count (entry_count)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count <= CW'(DEPTH))
		else $error("entry count above table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count != $past(entry_count) |-> entry_count == $past(entry_count) + CW'(1))
		else $error("entry count moved by other than one");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cm.emit |-> (!rsp.valid || rsp.ready))
		else $error("result overwrote a word not yet taken");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("second word taken while one is in progress");

endmodule

`default_nettype wire
